// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`default_nettype none
package tcw_pkg;

    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_HOME = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    localparam int IDX_W    = 11;
    localparam int GLYPH_W  = 8;
    localparam int CELL_W   = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic [2:0] {
        OP_GLYPH,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_HOME,
        OP_READ,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [GLYPH_W-1:0]   glyph;
        logic [IDX_W-1:0]     index;
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK
    } back_state_t;

endpackage
`default_nettype wire

// ===== src/tcw_front.sv =====
// Front end: input handshake and command classification.
`default_nettype none
module tcw_front import tcw_pkg::*; (
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]          s_tuser,
    input  wire logic                enable,
    input  wire logic                q_full,
    output logic                     push,
    output op_t                      op
);

    logic [GLYPH_W-1:0] glyph;

    assign glyph    = s_tdata[GLYPH_W-1:0];
    assign s_tready = enable && !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        op.glyph = glyph;
        op.index = s_tdata[GLYPH_W +: IDX_W];
        unique case (s_tuser)
            CMD_PUT: begin
                if (glyph == CH_NEWLINE) begin
                    op.kind = OP_NEWLINE;
                end else if (glyph == CH_BACKSPACE) begin
                    op.kind = OP_BACKSPACE;
                end else begin
                    op.kind = OP_GLYPH;
                end
            end
            CMD_HOME: op.kind = OP_HOME;
            CMD_READ: op.kind = OP_READ;
            default:  op.kind = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/tcw_queue.sv =====
// Two-entry operation queue between front and back end.
`default_nettype none
module tcw_queue import tcw_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire op_t  push_op,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output op_t       head
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

// ===== src/tcw_back.sv =====
// Back end: cell store, cursor, scrolling and result register.
`default_nettype none
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          attr,
    input  wire logic                q_empty,
    input  wire op_t                 q_head,
    output logic                     q_pop,
    output logic                     ready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int NCELL = COLUMNS * ROWS;
    localparam int CW    = $clog2(NCELL + 1);
    localparam int AW    = $clog2(NCELL);
    localparam int COLW  = $clog2(COLUMNS);

    localparam logic [CW-1:0]   LAST_CELL = CW'(NCELL - 1);
    localparam logic [CW-1:0]   LAST_ROW  = CW'(NCELL - COLUMNS);
    localparam logic [CW-1:0]   ROW_STEP  = CW'(COLUMNS);
    localparam logic [COLW-1:0] LAST_COL  = COLW'(COLUMNS - 1);

    logic [CELL_W-1:0] cell_mem [NCELL];
    logic [CELL_W-1:0] rd_data_reg;

    back_state_t     state_reg, state_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic            copy_pend_reg, copy_pend_next;
    logic [CW-1:0]   cursor_reg, cursor_next;
    logic [CW-1:0]   row_base_reg, row_base_next;
    logic [COLW-1:0] col_reg, col_next;
    logic            out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic              out_set;
    logic [CELL_W-1:0] res_data;
    logic              res_scrolled;
    logic [CELL_W-1:0] blank;
    logic [15:0]       idx_ext;
    logic [15:0]       cur_ext;
    logic [CW-1:0]     cursor_dec;
    logic [CW-1:0]     copy_dst;

    assign blank      = {attr, CH_SPACE};
    assign idx_ext    = 16'(q_head.index);
    assign cursor_dec = cursor_reg - CW'(1);
    assign copy_dst   = scan_reg - CW'(COLUMNS + 1);
    assign cur_ext    = 16'(cursor_next);
    assign ready      = (state_reg != ST_INIT);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        copy_pend_next = 1'b0;
        cursor_next    = cursor_reg;
        row_base_next  = row_base_reg;
        col_next       = col_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = '0;
        q_pop          = 1'b0;
        out_set        = 1'b0;
        res_data       = '0;
        res_scrolled   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                we    = 1'b1;
                waddr = scan_reg[AW-1:0];
                wdata = {RESET_ATTR, CH_SPACE};
                if (scan_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                    scan_next  = '0;
                end else begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            ST_IDLE: begin
                if (!q_empty && !out_valid_reg) begin
                    q_pop = 1'b1;
                    unique case (q_head.kind)
                        OP_GLYPH: begin
                            we    = 1'b1;
                            waddr = cursor_reg[AW-1:0];
                            wdata = {attr, q_head.glyph};
                            if (cursor_reg == LAST_CELL) begin
                                cursor_next   = LAST_ROW;
                                row_base_next = LAST_ROW;
                                col_next      = '0;
                                scan_next     = ROW_STEP;
                                state_next    = ST_SCROLL;
                            end else begin
                                cursor_next = cursor_reg + CW'(1);
                                out_set     = 1'b1;
                                if (col_reg == LAST_COL) begin
                                    col_next      = '0;
                                    row_base_next = row_base_reg + ROW_STEP;
                                end else begin
                                    col_next = col_reg + COLW'(1);
                                end
                            end
                        end
                        OP_NEWLINE: begin
                            col_next = '0;
                            if (row_base_reg == LAST_ROW) begin
                                cursor_next = row_base_reg;
                                scan_next   = ROW_STEP;
                                state_next  = ST_SCROLL;
                            end else begin
                                cursor_next   = row_base_reg + ROW_STEP;
                                row_base_next = row_base_reg + ROW_STEP;
                                out_set       = 1'b1;
                            end
                        end
                        OP_BACKSPACE: begin
                            out_set = 1'b1;
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_dec;
                                we          = 1'b1;
                                waddr       = cursor_dec[AW-1:0];
                                wdata       = blank;
                                if (col_reg == '0) begin
                                    col_next      = LAST_COL;
                                    row_base_next = row_base_reg - ROW_STEP;
                                end else begin
                                    col_next = col_reg - COLW'(1);
                                end
                            end
                        end
                        OP_HOME: begin
                            cursor_next   = '0;
                            row_base_next = '0;
                            col_next      = '0;
                            out_set       = 1'b1;
                        end
                        OP_READ: begin
                            if (idx_ext < 16'(NCELL)) begin
                                raddr      = idx_ext[AW-1:0];
                                state_next = ST_READ;
                            end else begin
                                out_set = 1'b1;
                            end
                        end
                        OP_NOP: out_set = 1'b1;
                        default: out_set = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                out_set    = 1'b1;
                res_data   = rd_data_reg;
                state_next = ST_IDLE;
            end
            ST_SCROLL: begin
                if (copy_pend_reg) begin
                    we    = 1'b1;
                    waddr = copy_dst[AW-1:0];
                    wdata = rd_data_reg;
                end
                if (scan_reg == CW'(NCELL)) begin
                    scan_next  = LAST_ROW;
                    state_next = ST_BLANK;
                end else begin
                    raddr          = scan_reg[AW-1:0];
                    copy_pend_next = 1'b1;
                    scan_next      = scan_reg + CW'(1);
                end
            end
            ST_BLANK: begin
                we    = 1'b1;
                waddr = scan_reg[AW-1:0];
                wdata = blank;
                if (scan_reg == LAST_CELL) begin
                    out_set      = 1'b1;
                    res_scrolled = 1'b1;
                    scan_next    = '0;
                    state_next   = ST_IDLE;
                end else begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            default: state_next = ST_INIT;
        endcase
        if (out_set) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            scan_reg      <= '0;
            copy_pend_reg <= 1'b0;
            cursor_reg    <= '0;
            row_base_reg  <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            copy_pend_reg <= copy_pend_next;
            cursor_reg    <= cursor_next;
            row_base_reg  <= row_base_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_set) begin
            out_data_reg <= {4'b0, res_scrolled, res_data, cur_ext[IDX_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            cell_mem[waddr] <= wdata;
        end
        rd_data_reg <= cell_mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/text_console_writer.sv =====
// Text console writer: teletype engine over a text-cell store.
// An input transaction is registered into the queue, then popped by the back end and registered as the
// result; an in-range read also passes through ST_READ. A scroll copies rows up, then blanks the bottom row.
// The back end starts an item only once the result register is free.
// Reset: cursor 0, attribute 15; then a clearing pass over all COLUMNS*ROWS cells, s_tready held low.
// A two-entry queue lets the input side keep accepting while a result or scroll is pending.
`default_nettype none
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data,  // text_attribute
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,      // char_code[7:0], read_index[18:8]
    input  wire logic [1:0]          s_tuser,      // command[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata       // cursor_position[10:0], cell_data[26:11],
                                                   // scrolled[27]
);

    logic [7:0] attr_reg;
    logic       push;
    op_t        push_op;
    logic       q_full;
    logic       q_empty;
    op_t        q_head;
    logic       q_pop;
    logic       back_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= RESET_ATTR;
        end else if (cfg_wr_en) begin
            attr_reg <= cfg_wr_data;
        end
    end

    tcw_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .enable   (back_ready),
        .q_full   (q_full),
        .push     (push),
        .op       (push_op)
    );

    tcw_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .head    (q_head)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .attr     (attr_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .ready    (back_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== src/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
`default_nettype none
module tcw_checker import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    localparam int NCELL = COLUMNS * ROWS;

    // no transactions taken as the clearing pass begins, just after reset
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (NCELL > 2048) || (16'(m_tdata[IDX_W-1:0]) < 16'(NCELL)))
        else $error("cursor beyond the cell store");

    // after a scroll the cursor sits at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |->
            (NCELL > 2048) || (m_tdata[IDX_W-1:0] == IDX_W'(NCELL - COLUMNS)))
        else $error("scroll left cursor off the bottom row start");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for text_console_writer: streamed console results against a predicted screen.
`timescale 1ns / 100ps
module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_W-1:0]  cursor;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } console_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [7:0]          cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted console state
    logic [CELL_W-1:0] screen_mem [CELLS];
    int                cursor_pos;
    logic [7:0]        text_attr;
    console_result_t   pending_results [$];

    int  error_count;
    int  cycle_count;
    int  command_count;
    int  read_count;
    int  scroll_count;
    int  attr_count;
    bit  gaps_on;
    bit  stalls_on;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),      // char_code[7:0], read_index[18:8]
        .s_tuser    (s_tuser),      // command[1:0]
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)       // cursor_position[10:0], cell_data[26:11], scrolled[27]
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [CELL_W-1:0] blank_cell();
        return {text_attr, CH_SPACE};
    endfunction

    function automatic logic scroll_if_needed();
        logic did;
        did = 1'b0;
        while (cursor_pos >= CELLS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_mem[i] = screen_mem[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_mem[i] = blank_cell();
            cursor_pos -= COLUMNS;
            did = 1'b1;
        end
        return did;
    endfunction

    task automatic predict_console(input logic [1:0] cmd, input logic [7:0] ch,
                                   input logic [IDX_W-1:0] idx);
        console_result_t res;
        res.cell_data = '0;
        res.scrolled  = 1'b0;
        case (cmd)
            CMD_PUT: begin
                if (ch == CH_NEWLINE) begin
                    cursor_pos   = (cursor_pos / COLUMNS + 1) * COLUMNS;
                    res.scrolled = scroll_if_needed();
                end else if (ch == CH_BACKSPACE) begin
                    if (cursor_pos > 0) begin
                        cursor_pos--;
                        screen_mem[cursor_pos] = blank_cell();
                    end
                end else begin
                    screen_mem[cursor_pos] = {text_attr, ch};
                    cursor_pos++;
                    res.scrolled = scroll_if_needed();
                end
            end
            CMD_HOME: cursor_pos = 0;
            CMD_READ: begin
                read_count++;
                if (idx < CELLS)
                    res.cell_data = screen_mem[idx];
            end
            default: ;
        endcase
        res.cursor = cursor_pos[IDX_W-1:0];
        pending_results.push_back(res);
    endtask

    // One input transaction; s_tvalid stays high into the next call unless a gap is taken
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] ch,
                                input logic [IDX_W-1:0] idx);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W - IDX_W - GLYPH_W){1'b0}}, idx, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        command_count++;
        predict_console(cmd, ch, idx);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_attribute(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        text_attr    = value;
        attr_count++;
    endtask

    function automatic logic [7:0] random_glyph();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        if ($urandom_range(0, 4) == 0)
            return IDX_W'($urandom_range(0, 2047));
        return IDX_W'($urandom_range(0, CELLS - 1));
    endfunction

    task automatic send_random_item(input int home_pct);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < home_pct) begin
            send_command(CMD_HOME, 8'($urandom), IDX_W'($urandom));
        end else if (r < home_pct + 3) begin
            send_command(CMD_UNUSED, 8'($urandom), IDX_W'($urandom));
        end else if (r < home_pct + 20) begin
            send_command(CMD_READ, 8'($urandom), random_index());
        end else begin
            k = $urandom_range(0, 99);
            if (k < 10)
                send_command(CMD_PUT, CH_NEWLINE, IDX_W'($urandom));
            else if (k < 18)
                send_command(CMD_PUT, CH_BACKSPACE, IDX_W'($urandom));
            else
                send_command(CMD_PUT, random_glyph(), IDX_W'($urandom));
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result transaction with nothing pending: %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[10:0] !== want.cursor)
                    report_mismatch($sformatf("cursor_position %0d, predicted %0d",
                                              m_tdata[10:0], want.cursor));
                if (m_tdata[26:11] !== want.cell_data)
                    report_mismatch($sformatf("cell_data %h, predicted %h",
                                              m_tdata[26:11], want.cell_data));
                if (m_tdata[27] !== want.scrolled)
                    report_mismatch($sformatf("scrolled %b, predicted %b",
                                              m_tdata[27], want.scrolled));
                if (want.scrolled)
                    scroll_count++;
            end
        end
    end

    // Result-side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic test_reset_screen();
        send_command(CMD_READ, 8'h00, IDX_W'(0));
        send_command(CMD_READ, 8'hFF, IDX_W'(CELLS - 1));
        send_command(CMD_READ, 8'h00, IDX_W'(CELLS));
        send_command(CMD_READ, 8'h00, IDX_W'(2047));
        send_command(CMD_UNUSED, 8'hFF, IDX_W'(2047));
        wait_drain();
    endtask

    task automatic test_put_cases();
        send_command(CMD_PUT, 8'h41, '0);
        send_command(CMD_PUT, 8'h00, '0);      // glyph 0 is printable
        send_command(CMD_PUT, 8'hFF, '1);
        send_command(CMD_READ, 8'h00, IDX_W'(0));
        send_command(CMD_READ, 8'h00, IDX_W'(1));
        send_command(CMD_READ, 8'h00, IDX_W'(2));
        send_command(CMD_PUT, CH_BACKSPACE, '0);
        send_command(CMD_READ, 8'h00, IDX_W'(2));
        send_command(CMD_PUT, CH_NEWLINE, '0);
        send_command(CMD_PUT, 8'h7A, '0);
        send_command(CMD_HOME, 8'hFF, '1);
        send_command(CMD_READ, 8'h00, IDX_W'(COLUMNS));
        send_command(CMD_PUT, CH_BACKSPACE, '0); // no effect at cell 0
        send_command(CMD_READ, 8'h00, IDX_W'(0));
        send_command(CMD_PUT, CH_NEWLINE, '0);
        send_command(CMD_PUT, CH_NEWLINE, '0);
        wait_drain();
    endtask

    task automatic test_attribute_sweep();
        logic [7:0] attrs [3];
        attrs[0] = 8'h00;
        attrs[1] = 8'hFF;
        attrs[2] = 8'($urandom);
        foreach (attrs[a]) begin
            set_attribute(attrs[a]);
            repeat (40) send_random_item(2);
            wait_drain();
        end
    endtask

    task automatic test_random_text();
        set_attribute(8'($urandom));
        repeat (650) send_random_item(2);
        wait_drain();
    endtask

    // Fill to the bottom row, then lines of text so that newlines and long lines scroll
    task automatic test_scroll_runs();
        int sent;
        int len;
        set_attribute(8'($urandom));
        send_command(CMD_HOME, 8'($urandom), IDX_W'($urandom));
        repeat (ROWS - 1) send_command(CMD_PUT, CH_NEWLINE, IDX_W'($urandom));
        sent = ROWS;
        while (sent < 220) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 95) : $urandom_range(0, 10);
            repeat (len) begin
                if ($urandom_range(0, 19) == 0)
                    send_command(CMD_READ, 8'($urandom), random_index());
                else if ($urandom_range(0, 29) == 0)
                    send_command(CMD_PUT, CH_BACKSPACE, IDX_W'($urandom));
                else
                    send_command(CMD_PUT, random_glyph(), IDX_W'($urandom));
            end
            sent += len;
            if ($urandom_range(0, 9) < 7) begin
                send_command(CMD_PUT, CH_NEWLINE, IDX_W'($urandom));
                sent++;
            end
        end
        wait_drain();
    endtask

    task automatic test_full_rate();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_attribute(RESET_ATTR);
        repeat (150) send_random_item(1);
        wait_drain();
    endtask

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        command_count = 0;
        read_count    = 0;
        scroll_count  = 0;
        attr_count    = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        cursor_pos    = 0;
        text_attr     = RESET_ATTR;
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = {RESET_ATTR, CH_SPACE};

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // let the clearing pass finish before anything else
        repeat (2) @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        test_reset_screen();
        test_put_cases();
        test_attribute_sweep();
        test_random_text();
        test_scroll_runs();
        test_full_rate();

        repeat (8) @(posedge aclk);
        $display("covered %0d commands (%0d reads), %0d scrolls, %0d attribute writes",
                 command_count, read_count, scroll_count, attr_count);
        $display("with idle gaps and back-pressure, then a final phase at full rate");
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
